### src/fgem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fgem_pkg;

    // Field widths fixed by the stream format
    localparam int PIX_W      = 16;
    localparam int EDGE_W     = 17;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_HEIGHT = 4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd480;

    // Neighbourhood of one accepted pixel
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] up_c;
        logic [PIX_W-1:0] up_m;
        logic [PIX_W-1:0] up_p;
        logic [PIX_W-1:0] prev;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             col_nz;
        logic             last_col;
        logic             last_row;
    } fgem_item_t;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              end_img;
    } fgem_res_t;

    // Up to three results caused by one pixel, slot 0 first
    typedef struct packed {
        logic [2:0]        vld;
        fgem_res_t [2:0]   res;
    } fgem_job_t;

    function automatic logic [PIX_W-1:0] abs_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    function automatic logic [EDGE_W-1:0] grad_sum(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        logic [EDGE_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s;
    endfunction

endpackage

`default_nettype wire

### src/fgem_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fgem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### src/fgem_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module fgem_line_buf #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_q;
    logic             byp_hit_reg;
    logic [WIDTH-1:0] byp_data_reg;

    fgem_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Forward a write that lands on the address being read in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
        byp_data_reg <= wr_data;
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : ram_q;

endmodule

`default_nettype wire

### src/fgem_grad.sv
`timescale 1ns / 1ps
`default_nettype none

module fgem_grad (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire fgem_pkg::fgem_item_t in_item,
    output logic                    in_ready,
    output logic                    job_valid,
    output fgem_pkg::fgem_job_t     job,
    input  wire logic               job_ready
);

    fgem_pkg::fgem_job_t job_next;
    fgem_pkg::fgem_job_t job_reg;
    logic                job_valid_reg;
    logic [fgem_pkg::PIX_W-1:0] hn;
    logic [fgem_pkg::PIX_W-1:0] d_prev;
    logic                in_acc;

    always_comb begin
        hn     = in_item.last_col ? in_item.up_m : in_item.up_p;
        d_prev = fgem_pkg::abs_diff(in_item.pix, in_item.prev);

        // Result for the pixel above: the new pixel is its lower neighbour
        job_next.vld[0]            = (in_item.row != '0);
        job_next.res[0].edge_value = fgem_pkg::grad_sum(fgem_pkg::abs_diff(hn, in_item.up_c),
                                                        fgem_pkg::abs_diff(in_item.pix,
                                                                           in_item.up_c));
        job_next.res[0].row        = in_item.row - 1'b1;
        job_next.res[0].col        = in_item.col;
        job_next.res[0].end_img    = 1'b0;

        // Last row: result for the pixel to the left
        job_next.vld[1]            = in_item.last_row && in_item.col_nz;
        job_next.res[1].edge_value = fgem_pkg::grad_sum(d_prev,
                                                        fgem_pkg::abs_diff(in_item.up_m,
                                                                           in_item.prev));
        job_next.res[1].row        = in_item.row;
        job_next.res[1].col        = in_item.col - 1'b1;
        job_next.res[1].end_img    = 1'b0;

        // Bottom right corner: left and upper neighbours
        job_next.vld[2]            = in_item.last_row && in_item.last_col;
        job_next.res[2].edge_value = fgem_pkg::grad_sum(d_prev,
                                                        fgem_pkg::abs_diff(in_item.up_c,
                                                                           in_item.pix));
        job_next.res[2].row        = in_item.row;
        job_next.res[2].col        = in_item.col;
        job_next.res[2].end_img    = 1'b1;
    end

    assign in_ready = !job_valid_reg || job_ready;
    assign in_acc   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (in_ready) begin
            // drop pixels of the first row: they cause no result yet
            job_valid_reg <= in_acc && (job_next.vld != 3'b000);
        end
        if (in_acc) begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

`default_nettype wire

### src/fgem_out.sv
`timescale 1ns / 1ps
`default_nettype none

module fgem_out (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                job_valid,
    input  wire fgem_pkg::fgem_job_t job,
    output logic                     job_ready,
    output logic                     out_valid,
    output fgem_pkg::fgem_res_t      out_res,
    output logic                     out_last,
    input  wire logic                out_ready
);

    logic [2:0]          pend_reg;
    logic [2:0]          sel;
    logic [2:0]          pend_after;
    fgem_pkg::fgem_job_t hold_reg;

    always_comb begin
        priority if (pend_reg[0]) begin
            sel = 3'b001;
        end else if (pend_reg[1]) begin
            sel = 3'b010;
        end else begin
            sel = {pend_reg[2], 2'b00};
        end
    end

    always_comb begin
        unique case (sel)
            3'b001:  out_res = hold_reg.res[0];
            3'b010:  out_res = hold_reg.res[1];
            default: out_res = hold_reg.res[2];
        endcase
    end

    assign out_valid  = (pend_reg != 3'b000);
    assign out_last   = ((pend_reg & ~sel) == 3'b000);
    assign pend_after = (out_valid && out_ready) ? (pend_reg & ~sel) : pend_reg;
    assign job_ready  = (pend_after == 3'b000);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 3'b000;
        end else if (job_valid && job_ready) begin
            pend_reg <= job.vld;
        end else begin
            pend_reg <= pend_after;
        end
        if (job_valid && job_ready) begin
            hold_reg <= job;
        end
    end

endmodule

`default_nettype wire

### src/forward_gradient_edge_map_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Forward-difference L1 edge map. Pixels enter in raster order, one per clock, and each
// result is |right - cur| + |below - cur| (left neighbour in the last column, upper one in
// the last row). The result for row r leaves while row r+1 streams in, so the first row
// yields nothing and the last row yields two results per pixel, one at its first column and
// three at its last. The input takes one pixel per clock whenever the single result port
// keeps up; in the last row the result port, one result per clock while m_tready is high,
// sets the pace. A pixel's results are registered in the gradient stage and then held in
// the output stage, which takes a new pixel's results only once the last ones have left.
// One line memory of MAX_WIDTH x PIXEL_BITS with a read-ahead port holds the previous row;
// it needs no clearing after reset. Width and height are clamped to [2, MAX_WIDTH] and
// [2, 4096] and are to be written only between beats with no results pending.
module forward_gradient_edge_map_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config
    input  wire logic                              cfg_wr_en,
    input  wire logic [fgem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fgem_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // pixel stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [15:0]                       s_tdata,   // [15:0] pixel_value
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [39:0]                            m_tdata,   // [16:0] edge_value,
                                                              // [28:17] out_row,
                                                              // [38:29] out_col
    output logic                                   m_tlast,   // last_of_run
    output logic [0:0]                             m_tuser    // [0] last_of_image
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [fgem_pkg::IMG_W_BITS-1:0] cfg_width_reg;
    logic [fgem_pkg::IMG_H_BITS-1:0] cfg_height_reg;

    logic [CW-1:0]                   col_reg, col_next, last_col_idx, rd_addr;
    logic [fgem_pkg::ROW_W-1:0]      row_reg, row_next, last_row_idx;
    logic                            last_col, last_row, s_acc;

    logic [PIXEL_BITS-1:0]           pix, up_next;
    logic [PIXEL_BITS-1:0]           up_c_reg, up_m_reg, first_pix_reg, prev_reg;

    fgem_pkg::fgem_item_t            item;
    fgem_pkg::fgem_job_t             job;
    logic                            job_valid, job_ready;
    fgem_pkg::fgem_res_t             res;
    logic                            grad_in_ready;

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= fgem_pkg::IMAGE_WIDTH_RESET;
            cfg_height_reg <= fgem_pkg::IMAGE_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fgem_pkg::CFG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_wdata[fgem_pkg::IMG_W_BITS-1:0];
                fgem_pkg::CFG_IMAGE_HEIGHT: cfg_height_reg <= cfg_wdata;
            endcase
        end
    end

    // Clamped last column and last row
    always_comb begin
        if (cfg_width_reg < 11'd2) begin
            last_col_idx = CW'(1);
        end else if (32'(cfg_width_reg) > MAX_WIDTH) begin
            last_col_idx = CW'(MAX_WIDTH - 1);
        end else begin
            last_col_idx = CW'(cfg_width_reg - 11'd1);
        end
        if (cfg_height_reg < 13'd2) begin
            last_row_idx = 12'd1;
        end else if (32'(cfg_height_reg) > fgem_pkg::MAX_HEIGHT) begin
            last_row_idx = 12'(fgem_pkg::MAX_HEIGHT - 1);
        end else begin
            last_row_idx = 12'(cfg_height_reg - 13'd1);
        end
    end

    assign last_col = (col_reg >= last_col_idx);
    assign last_row = (row_reg >= last_row_idx);
    assign s_tready = job_ready;
    assign s_acc    = s_tvalid && s_tready;
    assign pix      = s_tdata[PIXEL_BITS-1:0];

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_acc) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : (row_reg + 1'b1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
        // read ahead one column past the next pixel
        rd_addr = (col_next == CW'(MAX_WIDTH - 1)) ? col_next : (col_next + CW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line memory: writing over a column after its upper value has been taken
    fgem_line_buf #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_acc),
        .wr_addr (col_reg),
        .wr_data (pix),
        .rd_addr (rd_addr),
        .rd_data (up_next)
    );

    // Upper-row window and left neighbour
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            prev_reg <= pix;
            if (col_reg == '0) begin
                first_pix_reg <= pix;
            end
            if (last_col) begin
                up_c_reg <= first_pix_reg;
            end else begin
                up_m_reg <= up_c_reg;
                up_c_reg <= up_next;
            end
        end
    end

    always_comb begin
        item.pix      = 16'(pix);
        item.up_c     = 16'(up_c_reg);
        item.up_m     = 16'(up_m_reg);
        item.up_p     = 16'(up_next);
        item.prev     = 16'(prev_reg);
        item.row      = row_reg;
        item.col      = 10'(col_reg);
        item.col_nz   = (col_reg != '0);
        item.last_col = last_col;
        item.last_row = last_row;
    end

    fgem_grad u_grad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_item   (item),
        .in_ready  (job_ready),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (grad_in_ready)
    );

    fgem_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (grad_in_ready),
        .out_valid (m_tvalid),
        .out_res   (res),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

    assign m_tdata    = {1'b0, res.col, res.row, res.edge_value};
    assign m_tuser[0] = res.end_img;

    // Assertions
    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && last_col |=> col_reg == '0)
        else $error("column counter did not wrap after the last column");

    a_img_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && last_col && last_row |=> row_reg == '0 && col_reg == '0)
        else $error("counters did not return to zero at the end of the image");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("end of image beat is not the last beat of its run");

endmodule

`default_nettype wire

### test/fgem_gradient_checker.sv
`timescale 1ns / 1ps

module fgem_gradient_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [fgem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fgem_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [15:0]                       s_tdata,   // [15:0] pixel_value
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [39:0]                       m_tdata,   // [16:0] edge_value,
                                                              // [28:17] out_row,
                                                              // [38:29] out_col
    input  wire logic                              m_tlast,   // last_of_run
    input  wire logic [0:0]                        m_tuser,   // [0] last_of_image
    output int                                     mismatches,
    output int                                     grads_pending
);

    localparam int LINE_DEPTH = 1024;

    typedef struct packed {
        logic [fgem_pkg::EDGE_W-1:0] mag;
        logic [fgem_pkg::ROW_W-1:0]  row;
        logic [fgem_pkg::COL_W-1:0]  col;
        logic                        run_end;
        logic                        img_end;
    } grad_px_t;

    logic [fgem_pkg::PIX_W-1:0]      upper_line [LINE_DEPTH];
    logic [fgem_pkg::PIX_W-1:0]      cur_line [LINE_DEPTH];
    logic [fgem_pkg::IMG_W_BITS-1:0] img_w;
    logic [fgem_pkg::IMG_H_BITS-1:0] img_h;
    logic [fgem_pkg::ROW_W-1:0]      row_at;
    logic [fgem_pkg::COL_W-1:0]      col_at;
    grad_px_t                        grad_due_q [$];
    int                              fails = 0;

    function automatic int unsigned clamp_col(input int unsigned c);
        return (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
    endfunction

    function automatic int unsigned abs_gap(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic grad_px_t make_grad(input int unsigned mag, input int unsigned r,
                                           input int unsigned c, input bit img_end);
        grad_px_t g;
        g.mag     = mag[fgem_pkg::EDGE_W-1:0];
        g.row     = r[fgem_pkg::ROW_W-1:0];
        g.col     = c[fgem_pkg::COL_W-1:0];
        g.run_end = 1'b0;
        g.img_end = img_end;
        return g;
    endfunction

    // Work out the results one accepted pixel releases and advance the raster position
    function automatic void predict_gradients(input logic [fgem_pkg::PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned p;
        int unsigned ctr;
        bit          lc;
        bit          lr;
        grad_px_t    g [3];
        int          n;
        w = img_w;
        h = img_h;
        if (w < 2) w = 2;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h < 2) h = 2;
        if (h > fgem_pkg::MAX_HEIGHT) h = fgem_pkg::MAX_HEIGHT;
        p  = px;
        r  = row_at;
        c  = col_at;
        lc = (c >= w - 1);
        lr = (r >= h - 1);
        n  = 0;
        // pixel above, with this pixel as its lower neighbour
        if (r != 0) begin
            ctr  = upper_line[c];
            g[n] = make_grad(abs_gap(lc ? upper_line[clamp_col(c - 1)]
                                        : upper_line[clamp_col(c + 1)], ctr)
                             + abs_gap(p, ctr), r - 1, c, 1'b0);
            n++;
        end
        // in the last row the left pixel now has its right neighbour
        if (lr && c >= 1) begin
            ctr  = cur_line[c - 1];
            g[n] = make_grad(abs_gap(p, ctr) + abs_gap(upper_line[c - 1], ctr),
                             r, c - 1, 1'b0);
            n++;
        end
        // corner: left and upper neighbours
        if (lr && lc) begin
            g[n] = make_grad(abs_gap(cur_line[clamp_col(c - 1)], p)
                             + abs_gap(upper_line[c], p), r, c, 1'b1);
            n++;
        end
        for (int k = 0; k < n; k++) begin
            g[k].run_end = (k == n - 1);
            grad_due_q.push_back(g[k]);
        end
        cur_line[c] = px;
        if (lc) begin
            upper_line = cur_line;
            col_at     = '0;
            row_at     = lr ? '0 : row_at + 1'b1;
        end else begin
            col_at = col_at + 1'b1;
        end
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        grad_px_t want;
        if (!aresetn) begin
            img_w  = fgem_pkg::IMAGE_WIDTH_RESET;
            img_h  = fgem_pkg::IMAGE_HEIGHT_RESET;
            row_at = '0;
            col_at = '0;
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                cur_line[i]   = '0;
            end
            grad_due_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (grad_due_q.size() == 0) begin
                    $error("result beat with nothing expected: tdata %h", m_tdata);
                    fails++;
                end else begin
                    want = grad_due_q.pop_front();
                    check_field("edge_value", want.mag, m_tdata[16:0]);
                    check_field("out_row", want.row, m_tdata[28:17]);
                    check_field("out_col", want.col, m_tdata[38:29]);
                    check_field("last_of_run", want.run_end, m_tlast);
                    check_field("last_of_image", want.img_end, m_tuser[0]);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    fgem_pkg::CFG_IMAGE_WIDTH: begin
                        img_w = cfg_wdata[fgem_pkg::IMG_W_BITS-1:0];
                    end
                    fgem_pkg::CFG_IMAGE_HEIGHT: begin
                        img_h = cfg_wdata[fgem_pkg::IMG_H_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) predict_gradients(s_tdata);
        end
        mismatches    <= fails;
        grads_pending <= grad_due_q.size();
    end

endmodule

### test/tb_forward_gradient_edge_map_top.sv
`timescale 1ns / 1ps

module tb_forward_gradient_edge_map_top;

    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_PIXELS = 270;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [fgem_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fgem_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [39:0]                     m_tdata;
    logic                            m_tlast;
    logic [0:0]                      m_tuser;
    int                              mismatches;
    int                              grads_pending;
    bit                              steady    = 1'b0;
    logic [15:0]                     last_px   = '0;
    int                              random_sent = 0;

    forward_gradient_edge_map_top dut (.*);

    fgem_gradient_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // switch between idling and back-to-back stretches now and then
    initial forever begin
        repeat ($urandom_range(30, 300)) @(posedge aclk);
        steady <= ($urandom_range(0, 3) == 0);
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    // extremes, small steps from the previous pixel and wide random values
    function automatic logic [15:0] rand_px();
        case ($urandom_range(0, 7))
            0: begin
                last_px = '0;
            end
            1: begin
                last_px = '1;
            end
            2, 3: begin
                last_px = last_px + 16'($urandom_range(0, 30)) - 16'd15;
            end
            default: begin
                last_px = 16'($urandom);
            end
        endcase
        return last_px;
    endfunction

    task automatic send_px(input logic [15:0] px);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_image(input int count);
        repeat (count) send_px(rand_px());
    endtask

    // write only once every result is out and the pipeline has drained
    task automatic write_reg(input logic [fgem_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fgem_pkg::CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (grads_pending != 0);
        repeat (8) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_geometry(input logic [fgem_pkg::CFG_DATA_W-1:0] w_word,
                                input logic [fgem_pkg::CFG_DATA_W-1:0] h_word);
        write_reg(fgem_pkg::CFG_IMAGE_WIDTH, w_word);
        write_reg(fgem_pkg::CFG_IMAGE_HEIGHT, h_word);
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int w;
        int h;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry is wide and tall: start row 0, then narrow it mid-row
        send_px(16'h0000);
        send_px(16'hFFFF);
        send_px(16'h5A5A);
        write_reg(fgem_pkg::CFG_IMAGE_WIDTH, 13'd2);
        send_px(16'hA5A5);                    // column 3 now counts as the last one
        repeat (6) send_px(rand_px());
        write_reg(fgem_pkg::CFG_IMAGE_HEIGHT, 13'd3);   // row 4 is past the new last row
        repeat (2) send_px(rand_px());

        // sizes below the minimum clamp to 2x2
        set_geometry(13'd0, 13'd1);
        send_px('0);
        send_px('1);
        send_px('1);
        send_px('0);

        // width keeps only its low 11 bits
        set_geometry(13'h1803, 13'd2);
        repeat (3) begin
            send_px('1);
            send_px('0);
        end

        // small random images with random content
        while (random_sent < RANDOM_PIXELS) begin
            w = $urandom_range(0, 12);
            h = $urandom_range(0, 8);
            set_geometry({2'($urandom_range(0, 3)), 11'(w)}, 13'(h));
            if (w < 2) w = 2;
            if (h < 2) h = 2;
            send_image(w * h);
            random_sent += w * h;
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (grads_pending != 0);
        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
